@@ sv/huffman_code_builder_macros.svh @@
// Assertion macros for the Huffman code builder.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// Same-cycle implication.
`define HCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hcb_pkg.sv @@
// Shared types and constants for the Huffman code builder.
// No dependencies.
package hcb_pkg;
    localparam int MAX_SYMBOLS = 64;
    localparam int FREQ_BITS   = 24;
    localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
    localparam int LIST_AW     = $clog2(MAX_SYMBOLS);
    localparam int LIST_DEPTH  = 2 ** LIST_AW;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_AW     = $clog2(NODE_SLOTS + 1);
    localparam int W_BITS      = FREQ_BITS + LIST_AW;
    localparam int SYM_W       = 6;
    localparam int CODE_W      = 63;
    localparam int LEN_W       = 6;

    typedef struct packed {
        logic [W_BITS-1:0]  weight;
        logic [NODE_AW-1:0] node;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   pop;
        logic   clr;
        entry_t entry;
    } list_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } list_stat_t;

    typedef struct packed {
        logic [NODE_AW-1:0] node;
        logic [LEN_W-1:0]   len;
    } stk_t;
endpackage

@@ sv/hcb_sorted_list.sv @@
// Weight-sorted node list: circular memory, insertion by tail-first scan and shift.
// Depends on hcb_pkg and huffman_code_builder_macros.svh.
`include "huffman_code_builder_macros.svh"
module hcb_sorted_list (
    input  logic               aclk,
    input  logic               aresetn,
    input  hcb_pkg::list_cmd_t cmd,
    output hcb_pkg::list_stat_t stat,
    output hcb_pkg::entry_t    pop_data
);
    import hcb_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_SCAN = 3'b010,
        L_HEAD = 3'b100
    } lstate_t;

    lstate_t state_reg, state_next;
    logic [LIST_AW-1:0] head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIST_AW-1:0] pos_reg, pos_next;
    entry_t             new_reg, new_next;

    entry_t             mem [LIST_DEPTH];
    entry_t             rdata_reg;
    logic               we;
    logic [LIST_AW-1:0] waddr;
    entry_t             wdata;
    logic [LIST_AW-1:0] raddr;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        new_next   = new_reg;
        we         = 1'b0;
        waddr      = head_reg;
        wdata      = cmd.entry;
        raddr      = head_reg;
        unique case (state_reg)
            L_IDLE: begin
                priority if (cmd.clr) begin
                    head_next  = '0;
                    count_next = '0;
                end else if (cmd.ins) begin
                    new_next = cmd.entry;
                    if (count_reg == '0) begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        pos_next   = LIST_AW'(count_reg - 1'b1);
                        raddr      = head_reg + LIST_AW'(count_reg - 1'b1);
                        state_next = L_SCAN;
                    end
                end else if (cmd.pop) begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            L_SCAN: begin
                we    = 1'b1;
                waddr = head_reg + pos_reg + 1'b1;
                if (rdata_reg.weight > new_reg.weight) begin
                    wdata = rdata_reg;
                    if (pos_reg == '0) begin
                        state_next = L_HEAD;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                        raddr    = head_reg + pos_reg - 1'b1;
                    end
                end else begin
                    wdata      = new_reg;
                    count_next = count_reg + 1'b1;
                    state_next = L_IDLE;
                end
            end
            L_HEAD: begin
                we         = 1'b1;
                waddr      = head_reg;
                wdata      = new_reg;
                count_next = count_reg + 1'b1;
                state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_reg <= new_next;
    end

    assign stat.busy  = (state_reg != L_IDLE);
    assign stat.count = count_reg;
    assign pop_data   = rdata_reg;

    `HCB_ASSERT_NOW(a_cnt_max, 1'b1, count_reg <= CNT_W'(MAX_SYMBOLS), "list over capacity")
    `HCB_ASSERT_NOW(a_pop_nonempty, cmd.pop && state_reg == L_IDLE, count_reg != '0,
        "pop from empty list")
    `HCB_ASSERT_NEXT(a_head_done, state_reg == L_HEAD, state_reg == L_IDLE,
        "head write did not finish insertion")
endmodule

@@ sv/huffman_code_builder.sv @@
// Huffman code builder top level: load, merge and pre-order walk sequencer.
// Depends on hcb_pkg, hcb_sorted_list and huffman_code_builder_macros.svh.
//
//  channel | dir | words                        | handshake
//  s_      | in  | symbol, frequency, last      | s_valid / s_ready
//  m_      | out | symbol, code, length, end    | m_valid / m_ready
//
// Loading a word scans the list from the tail past every entry heavier than it
// (one compare per cycle in the list scan); into an empty list it is written
// directly. A merge pops the two lightest entries and inserts their sum; the walk
// visits every node in pre-order and emits one word per leaf.
// Reset clears control state only; s_ready is low from the last word until the
// final code word is taken. A stalled m_ready holds the sequencer.
`include "huffman_code_builder_macros.svh"
module huffman_code_builder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [hcb_pkg::SYM_W-1:0]    s_symbol,
    input  logic [23:0]                  s_frequency,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hcb_pkg::SYM_W-1:0]    m_out_symbol,
    output logic [hcb_pkg::CODE_W-1:0]   m_code,
    output logic [hcb_pkg::LEN_W-1:0]    m_code_length,
    output logic                         m_end_of_codes
);
    import hcb_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LWAIT = 11'b00000000010,
        S_MCHK  = 11'b00000000100,
        S_POPA  = 11'b00000001000,
        S_POPB  = 11'b00000010000,
        S_MWAIT = 11'b00000100000,
        S_ROOT  = 11'b00001000000,
        S_WRD   = 11'b00010000000,
        S_WDEC  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WPOP  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NODE_AW-1:0] nc_reg, nc_next;
    logic [NODE_AW-1:0] leaves_reg, leaves_next;
    logic               last_reg, last_next;
    entry_t             a_reg, a_next;
    logic [NODE_AW-1:0] n_reg, n_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;
    logic               mv_reg, mv_next;
    logic [SYM_W-1:0]   osym_reg, osym_next;
    logic [CODE_W-1:0]  ocode_reg, ocode_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;
    logic               oend_reg, oend_next;

    list_cmd_t  lcmd;
    list_stat_t lstat;
    entry_t     lpop;

    logic [SYM_W-1:0]     sym_mem [MAX_SYMBOLS];
    logic [2*NODE_AW-1:0] child_mem [NODE_SLOTS];
    stk_t                 stk_mem [MAX_SYMBOLS];
    logic [SYM_W-1:0]     sym_rd_reg;
    logic [2*NODE_AW-1:0] child_rd_reg;
    stk_t                 stk_rd_reg;
    logic                 sym_we, child_we, stk_we;
    logic [LIST_AW-1:0]   sym_waddr, stk_waddr, stk_raddr;
    logic [NODE_AW-1:0]   child_waddr;
    logic [2*NODE_AW-1:0] child_wdata;
    stk_t                 stk_wdata;
    logic [6:0]           shamt;

    hcb_sorted_list u_list (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (lcmd),
        .stat     (lstat),
        .pop_data (lpop)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        nc_next     = nc_reg;
        leaves_next = leaves_reg;
        last_next   = last_reg;
        a_next      = a_reg;
        n_next      = n_reg;
        code_next   = code_reg;
        len_next    = len_reg;
        sp_next     = sp_reg;
        mv_next     = mv_reg;
        osym_next   = osym_reg;
        ocode_next  = ocode_reg;
        olen_next   = olen_reg;
        oend_next   = oend_reg;
        lcmd        = '0;
        sym_we      = 1'b0;
        sym_waddr   = nc_reg[LIST_AW-1:0];
        child_we    = 1'b0;
        child_waddr = nc_reg;
        child_wdata = {a_reg.node, lpop.node};
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[LIST_AW-1:0];
        stk_wdata   = '{node: child_rd_reg[NODE_AW-1:0], len: len_reg + 1'b1};
        stk_raddr   = LIST_AW'(sp_reg - 1'b1);
        shamt       = {1'b0, len_reg} - {1'b0, stk_rd_reg.len} + 7'd1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next = s_last;
                    if (lstat.count < CNT_W'(MAX_SYMBOLS)) begin
                        sym_we       = 1'b1;
                        lcmd.ins     = 1'b1;
                        lcmd.entry.weight = W_BITS'(s_frequency[FREQ_BITS-1:0]);
                        lcmd.entry.node   = nc_reg;
                        nc_next      = nc_reg + 1'b1;
                        state_next   = S_LWAIT;
                    end else if (s_last) begin
                        leaves_next = nc_reg;
                        state_next  = S_MCHK;
                    end
                end
            end
            S_LWAIT: begin
                if (!lstat.busy) begin
                    if (last_reg) begin
                        leaves_next = nc_reg;
                        state_next  = S_MCHK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MCHK: begin
                lcmd.pop = 1'b1;
                state_next = (lstat.count == CNT_W'(1)) ? S_ROOT : S_POPA;
            end
            S_POPA: begin
                a_next     = lpop;
                lcmd.pop   = 1'b1;
                state_next = S_POPB;
            end
            S_POPB: begin
                child_we          = 1'b1;
                lcmd.ins          = 1'b1;
                lcmd.entry.weight = a_reg.weight + lpop.weight;
                lcmd.entry.node   = nc_reg;
                nc_next           = nc_reg + 1'b1;
                state_next        = S_MWAIT;
            end
            S_MWAIT: begin
                if (!lstat.busy) begin
                    state_next = S_MCHK;
                end
            end
            S_ROOT: begin
                n_next     = lpop.node;
                code_next  = '0;
                len_next   = '0;
                sp_next    = '0;
                state_next = S_WRD;
            end
            S_WRD: begin
                state_next = S_WDEC;
            end
            S_WDEC: begin
                if (n_reg < leaves_reg) begin
                    mv_next    = 1'b1;
                    osym_next  = sym_rd_reg;
                    ocode_next = code_reg;
                    olen_next  = len_reg;
                    oend_next  = (sp_reg == '0);
                    state_next = S_EMIT;
                end else begin
                    stk_we     = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    n_next     = child_rd_reg[2*NODE_AW-1:NODE_AW];
                    code_next  = code_reg << 1;
                    len_next   = len_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (sp_reg == '0) begin
                        lcmd.clr   = 1'b1;
                        nc_next    = '0;
                        state_next = S_IDLE;
                    end else begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_WPOP;
                    end
                end
            end
            S_WPOP: begin
                n_next     = stk_rd_reg.node;
                len_next   = stk_rd_reg.len;
                code_next  = ((code_reg >> shamt[5:0]) << 1) | CODE_W'(1);
                state_next = S_WRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_waddr] <= s_symbol;
        end
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        sym_rd_reg   <= sym_mem[n_reg[LIST_AW-1:0]];
        child_rd_reg <= child_mem[n_reg];
        stk_rd_reg   <= stk_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nc_reg    <= '0;
            sp_reg    <= '0;
            mv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            nc_reg    <= nc_next;
            sp_reg    <= sp_next;
            mv_reg    <= mv_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        leaves_reg <= leaves_next;
        a_reg      <= a_next;
        n_reg      <= n_next;
        code_reg   <= code_next;
        len_reg    <= len_next;
        osym_reg   <= osym_next;
        ocode_reg  <= ocode_next;
        olen_reg   <= olen_next;
        oend_reg   <= oend_next;
    end

    assign m_valid        = mv_reg;
    assign m_out_symbol   = osym_reg;
    assign m_code         = ocode_reg;
    assign m_code_length  = olen_reg;
    assign m_end_of_codes = oend_reg;

    `HCB_ASSERT_NOW(a_valid_emit, m_valid, state_reg == S_EMIT, "word shown outside emit")
    `HCB_ASSERT_NOW(a_no_overlap, m_valid, !s_ready, "input taken while word pending")
    `HCB_ASSERT_NOW(a_end_stack, m_valid && m_end_of_codes, sp_reg == '0,
        "end of codes with pending branches")
    `HCB_ASSERT_NEXT(a_end_idle, m_valid && m_ready && m_end_of_codes, s_ready,
        "no return to load after final word")
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for huffman_code_builder: drives symbol sets and checks
// every emitted code word against a behavioural tree builder held in a scoreboard.
// Depends on hcb_pkg and the huffman_code_builder RTL.
`timescale 1ns / 1ps

module tb_top;
    import hcb_pkg::*;

    typedef struct {
        bit [SYM_W-1:0]  sym;
        bit [CODE_W-1:0] code;
        bit [LEN_W-1:0]  len;
        bit              eoc;
    } code_word_t;

    class huff_scoreboard;
        bit [63:0]      weight[NODE_SLOTS];
        int             left_of[NODE_SLOTS];
        int             right_of[NODE_SLOTS];
        bit [SYM_W-1:0] sym_of[NODE_SLOTS];
        int             by_weight[MAX_SYMBOLS];
        int             n_list;
        int             n_nodes;
        code_word_t     codes_due[$];
        int             errors;

        function void place(int n);
            int pos;
            pos = 0;
            if (n_list >= MAX_SYMBOLS) return;
            while (pos < n_list && weight[by_weight[pos]] <= weight[n]) pos++;
            for (int i = n_list; i > pos; i--) by_weight[i] = by_weight[i-1];
            by_weight[pos] = n;
            n_list++;
        endfunction

        function int take_lightest();
            int n;
            n = by_weight[0];
            for (int i = 1; i < n_list; i++) by_weight[i-1] = by_weight[i];
            n_list--;
            return n;
        endfunction

        function void load_symbol(bit [5:0] sym, bit [23:0] freq, bit last);
            int         leaves, a, b, sp, n;
            int         st_node[2*MAX_SYMBOLS+2];
            bit [62:0]  st_code[2*MAX_SYMBOLS+2];
            int         st_len[2*MAX_SYMBOLS+2];
            code_word_t w;
            if (n_list < MAX_SYMBOLS && n_nodes < NODE_SLOTS) begin
                weight[n_nodes] = 64'(freq);
                sym_of[n_nodes] = sym;
                n_nodes++;
                place(n_nodes - 1);
            end
            if (!last || n_list == 0) return;
            leaves = n_nodes;
            while (n_list > 1) begin
                a = take_lightest();
                b = take_lightest();
                weight[n_nodes] = weight[a] + weight[b];
                left_of[n_nodes] = a;
                right_of[n_nodes] = b;
                n_nodes++;
                place(n_nodes - 1);
            end
            st_node[0] = by_weight[0];
            st_code[0] = '0;
            st_len[0] = 0;
            sp = 1;
            while (sp > 0) begin
                sp--;
                n = st_node[sp];
                if (n < leaves) begin
                    w.sym = sym_of[n];
                    w.code = st_code[sp];
                    w.len = LEN_W'(st_len[sp]);
                    w.eoc = 0;
                    codes_due.push_back(w);
                end else begin
                    st_node[sp+1] = left_of[n];
                    st_code[sp+1] = st_code[sp] << 1;
                    st_len[sp+1] = st_len[sp] + 1;
                    st_node[sp] = right_of[n];
                    st_code[sp] = (st_code[sp] << 1) | 63'd1;
                    st_len[sp] = st_len[sp] + 1;
                    sp += 2;
                end
            end
            codes_due[$].eoc = 1;
            n_list = 0;
            n_nodes = 0;
        endfunction

        function void check_code(bit [5:0] sym, bit [62:0] code, bit [5:0] len, bit eoc);
            code_word_t e;
            if (codes_due.size() == 0) begin
                $display("%0t: unexpected code word sym=%0d code=%h len=%0d",
                         $time, sym, code, len);
                errors++;
                return;
            end
            e = codes_due.pop_front();
            if (sym != e.sym) begin
                $display("%0t: symbol exp %0d got %0d", $time, e.sym, sym);
                errors++;
            end
            if (code != e.code) begin
                $display("%0t: code exp %h got %h", $time, e.code, code);
                errors++;
            end
            if (len != e.len) begin
                $display("%0t: length exp %0d got %0d", $time, e.len, len);
                errors++;
            end
            if (eoc != e.eoc) begin
                $display("%0t: end flag exp %0b got %0b", $time, e.eoc, eoc);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    logic [SYM_W-1:0]  s_symbol = '0;
    logic [23:0]       s_frequency = '0;
    logic              s_last = 0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [SYM_W-1:0]  m_out_symbol;
    logic [CODE_W-1:0] m_code;
    logic [LEN_W-1:0]  m_code_length;
    logic              m_end_of_codes;

    huff_scoreboard sb = new();
    bit             send_calm;
    bit             take_calm;
    int             sent;

    always #6 aclk = ~aclk;

    huffman_code_builder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_symbol(s_symbol),
        .s_frequency(s_frequency), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_symbol(m_out_symbol),
        .m_code(m_code), .m_code_length(m_code_length), .m_end_of_codes(m_end_of_codes)
    );

    task automatic send_word(bit [5:0] sym, bit [23:0] freq, bit last);
        int gap;
        gap = send_calm ? 0 : $urandom_range(6);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_symbol <= sym;
        s_frequency <= freq;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.load_symbol(sym, freq, last);
        sent++;
    endtask

    // kind: 0 full range, 1 heavy ties, 2 fibonacci (deep codes), 3 one symbol repeated
    task automatic send_set(int size, int kind);
        bit [23:0] f, fa, fb;
        bit [5:0]  sym;
        fa = 1;
        fb = 1;
        sym = 6'($urandom_range(63));
        for (int i = 0; i < size; i++) begin
            case (kind)
                0: f = 24'($urandom());
                1: f = 24'($urandom_range(3));
                2: begin
                    f = fa;
                    fa = fb;
                    fb = f + fb;
                end
                default: f = 24'($urandom_range(1000));
            endcase
            send_word(kind == 3 ? sym : 6'($urandom_range(63)), f, i == size - 1);
        end
        send_calm = ($urandom_range(3) == 0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // single-, two- and three-symbol sets, zero and full-scale weights
        send_word(6'd0, 24'd0, 1);
        send_word(6'd63, 24'hFFFFFF, 1);
        send_word(6'd63, 24'hFFFFFF, 0);
        send_word(6'd0, 24'd0, 1);
        send_word(6'd21, 24'hFFFFFF, 0);
        send_word(6'd42, 24'hFFFFFF, 0);
        send_word(6'd5, 24'h000001, 1);
        // duplicate symbols, equal weights and a fibonacci set
        send_set(4, 3);
        send_set(5, 1);
        send_set(6, 2);
        s_valid <= 0;
        while (sb.codes_due.size() != 0) @(posedge aclk);
        while (sent < 360) begin
            case ($urandom_range(19))
                0: send_set(36, 2);
                1: send_set(64, 0);
                2: send_set($urandom_range(65, 68), $urandom_range(1));
                3, 4: send_set($urandom_range(1, 16), 1);
                5: send_set($urandom_range(2, 10), 3);
                default: send_set($urandom_range(1, 8), 0);
            endcase
        end
        s_valid <= 0;
        while (sb.codes_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int gap, taken;
        taken = 0;
        @(posedge aclk);
        forever begin
            gap = take_calm ? 0 : $urandom_range(6);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            sb.check_code(m_out_symbol, m_code, m_code_length, m_end_of_codes);
            taken++;
            if (taken % 40 == 0) take_calm = ~take_calm;
        end
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/hcb_pkg.sv
sv/hcb_sorted_list.sv
sv/huffman_code_builder.sv
test/tb_top.sv
